### design/sprm_pkg.sv
// shared types and constants for the stereo peak/rms level meter
// no dependencies
package sprm_pkg;
    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 59;
    localparam int LEN_W    = 13;
    localparam int COEF_W   = 17;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;
    localparam int MAX_BLOCK = 4096;
    localparam int RES_W    = 30;  // root of a 59-bit value

    localparam logic [IDX_W-1:0] REG_BLOCK_LEN = 3'd0;
    localparam logic [IDX_W-1:0] REG_PEAK_DEC  = 3'd1;
    localparam logic [IDX_W-1:0] REG_RMS_ATK   = 3'd2;
    localparam logic [IDX_W-1:0] REG_RMS_REL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PEAK_FLR  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RMS_FLR   = 3'd5;

    localparam logic [COEF_W-1:0] Q_ONE = 17'd65536;

    // controller to datapath commands
    typedef struct packed {
        logic accum;      // fold in a frame
        logic fin_start;  // latch block and begin channel finish
        logic div_step;   // one divide bit
        logic sqrt_step;  // one root step
        logic sqrt_init;
        logic level_upd;  // write levels for current channel
        logic next_ch;    // move to right channel
        logic clear_acc;
    } t_cmd;

    typedef struct packed {
        logic ch;
    } t_sts;
endpackage

### design/sprm_ctrl.sv
// controller for the level meter: frame counting and end-of-block sequencing
// depends on sprm_pkg
module sprm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [sprm_pkg::LEN_W-1:0] i_block_length,
    output logic [sprm_pkg::LEN_W-1:0] o_frames,
    output sprm_pkg::t_cmd             o_cmd,
    output logic                       o_ch
);
    import sprm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [5:0]       r_step, n_step;
    logic             r_ch, n_ch;
    logic             r_ovalid, n_ovalid;
    logic [LEN_W-1:0] w_len, w_frames;
    logic             w_acc;

    // effective block length
    always_comb begin
        w_len = i_block_length;
        if (w_len == '0) w_len = LEN_W'(1);
        if (w_len > LEN_W'(MAX_BLOCK)) w_len = LEN_W'(MAX_BLOCK);
    end

    assign w_frames    = r_cnt + LEN_W'(1);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_frames    = w_frames;
    assign o_ch        = r_ch;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_ch     = r_ch;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && !i_out_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.accum = 1'b1;
                    if (w_frames < w_len) begin
                        n_cnt = w_frames;
                    end else begin
                        o_cmd.fin_start = 1'b1;
                        n_cnt   = r_cnt;
                        n_ch    = 1'b0;
                        n_step  = 6'd0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 6'd1;
                if (r_step == 6'(SUM_W - 1)) begin
                    n_step  = 6'd0;
                    n_state = S_SQRT;
                    o_cmd.sqrt_init = 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 6'd1;
                if (r_step == 6'(RES_W - 1)) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.level_upd = 1'b1;
                if (r_ch == 1'b0) begin
                    o_cmd.next_ch = 1'b1;
                    n_ch    = 1'b1;
                    n_step  = 6'd0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.clear_acc = 1'b1;
                    n_ovalid = 1'b1;
                    n_cnt    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_ch     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

### design/sprm_dp.sv
// datapath for the level meter: accumulators, serial divider and root, level math
// depends on sprm_pkg
module sprm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sprm_pkg::t_cmd                i_cmd,
    input  logic                          i_ch,
    input  logic [sprm_pkg::LEN_W-1:0]    i_frames,
    input  logic [sprm_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic [sprm_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic [sprm_pkg::COEF_W-1:0]   i_peak_decay,
    input  logic [sprm_pkg::COEF_W-1:0]   i_rms_atk,
    input  logic [sprm_pkg::COEF_W-1:0]   i_rms_rel,
    input  logic [sprm_pkg::CFG_W-1:0]    i_peak_floor,
    input  logic [sprm_pkg::CFG_W-1:0]    i_rms_floor,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_peak_left,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_peak_right,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_rms_left,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_rms_right
);
    import sprm_pkg::*;

    logic [SAMPLE_W-1:0] r_bpk [2];
    logic [SUM_W-1:0]    r_sum [2];
    logic [SAMPLE_W-1:0] r_pk  [2];
    logic [SAMPLE_W-1:0] r_rms [2];
    logic [SAMPLE_W-1:0] r_out [4];
    logic [LEN_W-1:0]    r_div;
    logic [SUM_W-1:0]    r_quo;
    logic [LEN_W:0]      r_rem;
    logic [SUM_W:0]      r_rad;
    logic [RES_W-1:0]    r_root;
    logic [RES_W+1:0]    r_srem;
    logic [SAMPLE_W-1:0] w_mag [2];
    logic [LEN_W:0]      w_rsh;
    logic [RES_W+1:0]    w_trial, w_ssh;
    logic [SAMPLE_W-1:0] w_brms, w_cur, w_np, w_nr;
    logic [SAMPLE_W+COEF_W:0] w_dec, w_mix;
    logic [COEF_W-1:0]   w_c, w_k;

    // sample magnitude, most negative maps to full scale
    always_comb begin
        w_mag[0] = i_left_sample[SAMPLE_W-1]  ? (~i_left_sample + 1'b1)  : i_left_sample;
        w_mag[1] = i_right_sample[SAMPLE_W-1] ? (~i_right_sample + 1'b1) : i_right_sample;
    end

    // restoring divide step and root step, radicand padded to an even width
    assign w_rsh   = {r_rem[LEN_W-1:0], r_quo[SUM_W-1]};
    assign w_ssh   = {r_srem[RES_W-1:0], r_rad[SUM_W:SUM_W-1]};
    assign w_trial = {r_root, 2'b01};

    // level update math for the current channel
    always_comb begin
        w_c    = i_peak_decay > Q_ONE ? Q_ONE : i_peak_decay;
        w_brms = SAMPLE_W'(r_root);
        w_cur  = r_rms[i_ch];
        w_k    = (w_brms > w_cur) ? i_rms_atk : i_rms_rel;
        if (w_k > Q_ONE) w_k = Q_ONE;
        w_dec  = (SAMPLE_W+COEF_W+1)'(r_pk[i_ch] * w_c) + 42'd32768;
        w_np   = (w_dec[SAMPLE_W+15:16] > r_bpk[i_ch]) ? w_dec[SAMPLE_W+15:16] : r_bpk[i_ch];
        if (w_np < i_peak_floor) w_np = '0;
        w_mix  = (SAMPLE_W+COEF_W+1)'(w_k * w_cur)
               + (SAMPLE_W+COEF_W+1)'((Q_ONE - w_k) * w_brms) + 42'd32768;
        w_nr   = w_mix[SAMPLE_W+15:16];
        if (w_nr < i_rms_floor) w_nr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_bpk[i] <= '0;
                r_sum[i] <= '0;
                r_pk[i]  <= '0;
                r_rms[i] <= '0;
            end
        end else begin
            if (i_cmd.accum) begin
                for (int i = 0; i < 2; i++) begin
                    if (w_mag[i] > r_bpk[i]) r_bpk[i] <= w_mag[i];
                    r_sum[i] <= r_sum[i] + SUM_W'(w_mag[i] * w_mag[i]);
                end
            end
            if (i_cmd.level_upd) begin
                r_pk[i_ch]  <= w_np;
                r_rms[i_ch] <= w_nr;
            end
            if (i_cmd.clear_acc) begin
                for (int i = 0; i < 2; i++) begin
                    r_bpk[i] <= '0;
                    r_sum[i] <= '0;
                end
            end
        end
    end

    // divider and root registers, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_start) begin
            r_div <= i_frames;
            r_rem <= '0;
            // include the frame being accepted this cycle
            r_quo <= r_sum[0] + SUM_W'(w_mag[0] * w_mag[0]);
        end else if (i_cmd.next_ch) begin
            r_rem <= '0;
            r_quo <= r_sum[1];
        end else if (i_cmd.div_step) begin
            if (w_rsh >= {1'b0, r_div}) begin
                r_rem <= w_rsh - {1'b0, r_div};
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sqrt_init) begin
            // final quotient, last bit taken from the closing divide step
            r_rad  <= {1'b0, r_quo[SUM_W-2:0], w_rsh >= {1'b0, r_div}};
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[SUM_W-2:0], 2'b00};
            if (w_ssh >= w_trial) begin
                r_srem <= w_ssh - w_trial;
                r_root <= {r_root[RES_W-2:0], 1'b1};
            end else begin
                r_srem <= w_ssh;
                r_root <= {r_root[RES_W-2:0], 1'b0};
            end
        end
        if (i_cmd.clear_acc) begin
            r_out[0] <= r_pk[0];
            r_out[1] <= r_pk[1];
            r_out[2] <= r_rms[0];
            r_out[3] <= r_rms[1];
        end
    end

    assign o_peak_left  = r_out[0];
    assign o_peak_right = r_out[1];
    assign o_rms_left   = r_out[2];
    assign o_rms_right  = r_out[3];
endmodule

### design/stereo_peak_rms_level_meter_top.sv
// top level of the stereo peak/rms level meter: config registers and wiring
// depends on sprm_pkg, sprm_ctrl, sprm_dp
//
// Input channel: one stereo frame per request (i_in_valid / o_in_stall).
// Output channel: all four levels per request (o_out_valid / i_out_stall),
// one request at the end of every metering block, none for other frames.
// A frame that does not close a block is taken without a stall.
// The closing frame starts a finish sequence run per channel by one
// bit-serial divider and one bit-serial square root plus a level
// update, then loads the output register. Input is stalled during
// that time. The output register holds its levels while i_out_stall
// is high; the next frame is accepted meanwhile, but a further block
// end waits. Reset (synchronous, active low) clears levels,
// accumulators and the frame count and loads the register defaults.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, by
// the user only while the block is idle; the block does not enforce it.
module stereo_peak_rms_level_meter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sprm_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [sprm_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sprm_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic [sprm_pkg::SAMPLE_W-1:0] i_right_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_peak_left,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_peak_right,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_rms_left,
    output logic [sprm_pkg::SAMPLE_W-1:0] o_rms_right
);
    import sprm_pkg::*;

    logic [LEN_W-1:0]  r_blen;
    logic [COEF_W-1:0] r_pdec, r_ratk, r_rrel;
    logic [CFG_W-1:0]  r_pflr, r_rflr;
    logic [LEN_W-1:0]  w_frames;
    logic              w_ch;
    t_cmd              w_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen <= LEN_W'(1024);
            r_pdec <= Q_ONE;
            r_ratk <= '0;
            r_rrel <= '0;
            r_pflr <= CFG_W'(8389);
            r_rflr <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_LEN: r_blen <= i_cfg_data[LEN_W-1:0];
                REG_PEAK_DEC:  r_pdec <= i_cfg_data[COEF_W-1:0];
                REG_RMS_ATK:   r_ratk <= i_cfg_data[COEF_W-1:0];
                REG_RMS_REL:   r_rrel <= i_cfg_data[COEF_W-1:0];
                REG_PEAK_FLR:  r_pflr <= i_cfg_data;
                REG_RMS_FLR:   r_rflr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sprm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_block_length(r_blen), .o_frames(w_frames),
        .o_cmd(w_cmd), .o_ch(w_ch)
    );

    sprm_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_ch(w_ch), .i_frames(w_frames),
        .i_left_sample(i_left_sample), .i_right_sample(i_right_sample),
        .i_peak_decay(r_pdec), .i_rms_atk(r_ratk), .i_rms_rel(r_rrel),
        .i_peak_floor(r_pflr), .i_rms_floor(r_rflr),
        .o_peak_left(o_peak_left), .o_peak_right(o_peak_right),
        .o_rms_left(o_rms_left), .o_rms_right(o_rms_right)
    );

    // a new result only appears when the previous one was taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_peak_left))
        else $error("output dropped while stalled");

    // at most one of accumulate, divide step, root step and level update at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.div_step, w_cmd.sqrt_step, w_cmd.level_upd, w_cmd.accum}) <= 1)
        else $error("conflicting datapath commands");

    // input stalled while finishing a block
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin_start |=> o_in_stall)
        else $error("input not stalled during finish");
endmodule

### tb/sv/tb.sv
// self-checking testbench for the stereo peak/rms level meter
// depends on sprm_pkg and stereo_peak_rms_level_meter_top
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sprm_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_UNUSED_B = 3'd7;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } frame_t;

    typedef struct {
        logic [SAMPLE_W-1:0] peak_l;
        logic [SAMPLE_W-1:0] peak_r;
        logic [SAMPLE_W-1:0] rms_l;
        logic [SAMPLE_W-1:0] rms_r;
    } levels_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [SAMPLE_W-1:0] i_left_sample;
    logic [SAMPLE_W-1:0] i_right_sample;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [SAMPLE_W-1:0] o_peak_left;
    logic [SAMPLE_W-1:0] o_peak_right;
    logic [SAMPLE_W-1:0] o_rms_left;
    logic [SAMPLE_W-1:0] o_rms_right;

    stereo_peak_rms_level_meter_top u_dut (.*);

    // meter state mirrored by the predictor
    logic [LEN_W-1:0]    m_block_len;
    logic [COEF_W-1:0]   m_peak_dec, m_rms_atk, m_rms_rel;
    logic [SAMPLE_W-1:0] m_peak_flr, m_rms_flr;
    logic [63:0]         m_blk_peak [2];
    logic [63:0]         m_sq_sum [2];
    int unsigned         m_frames;
    logic [63:0]         m_peak_lvl [2];
    logic [63:0]         m_rms_lvl [2];

    frame_t  frame_q [$];
    levels_t levels_q [$];
    int      errors = 0;
    int      cycles = 0;
    bit      send_hold = 0;
    bit      long_hold_req = 0;

    // clock
    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] clamp_q(logic [COEF_W-1:0] c);
        return (c > Q_ONE) ? 64'(Q_ONE) : 64'(c);
    endfunction

    // close a block on one channel
    task automatic close_channel(int ch, int unsigned frames);
        logic [63:0] dec, np, brms, k, nr;
        dec = (m_peak_lvl[ch] * clamp_q(m_peak_dec) + 64'd32768) >> 16;
        np = (dec > m_blk_peak[ch]) ? dec : m_blk_peak[ch];
        if (np < 64'(m_peak_flr)) np = 0;
        m_peak_lvl[ch] = np;
        brms = root_floor(m_sq_sum[ch] / 64'(frames));
        k = clamp_q(brms > m_rms_lvl[ch] ? m_rms_atk : m_rms_rel);
        nr = (k * m_rms_lvl[ch] + (64'd65536 - k) * brms + 64'd32768) >> 16;
        if (nr < 64'(m_rms_flr)) nr = 0;
        m_rms_lvl[ch] = nr;
        m_blk_peak[ch] = 0;
        m_sq_sum[ch] = 0;
    endtask

    // fold one accepted frame into the meter state
    task automatic meter_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
        logic [63:0] mag;
        int signed sv;
        int unsigned len, frames;
        levels_t lv;
        for (int ch = 0; ch < 2; ch++) begin
            sv = (ch == 0) ? $signed(l) : $signed(r);
            mag = (sv < 0) ? 64'(-sv) : 64'(sv);
            if (mag > m_blk_peak[ch]) m_blk_peak[ch] = mag;
            m_sq_sum[ch] += mag * mag;
        end
        len = m_block_len;
        if (len == 0) len = 1;
        if (len > MAX_BLOCK) len = MAX_BLOCK;
        frames = m_frames + 1;
        if (frames < len) begin
            m_frames = frames;
        end else begin
            close_channel(0, frames);
            close_channel(1, frames);
            m_frames = 0;
            lv.peak_l = m_peak_lvl[0][SAMPLE_W-1:0];
            lv.peak_r = m_peak_lvl[1][SAMPLE_W-1:0];
            lv.rms_l = m_rms_lvl[0][SAMPLE_W-1:0];
            lv.rms_r = m_rms_lvl[1][SAMPLE_W-1:0];
            levels_q.push_back(lv);
        end
    endtask

    // driver: bursts of requests with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                meter_frame(i_left_sample, i_right_sample);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (frame_q.size() > 0 && !send_hold) begin
                    frame_t f;
                    f = frame_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_left_sample <= f.left;
                    i_right_sample <= f.right;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off on request
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (long_hold_req && hold_left == 0) begin
            hold_left = 400;
            long_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // monitor: compare each result request with the oldest expected levels
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (levels_q.size() == 0) begin
                $display("%0t: unexpected result peak %0d/%0d rms %0d/%0d", $time,
                         o_peak_left, o_peak_right, o_rms_left, o_rms_right);
                errors++;
            end else begin
                levels_t e;
                e = levels_q.pop_front();
                if (o_peak_left !== e.peak_l) begin
                    $display("%0t: peak_left exp %0d got %0d", $time, e.peak_l, o_peak_left);
                    errors++;
                end
                if (o_peak_right !== e.peak_r) begin
                    $display("%0t: peak_right exp %0d got %0d", $time, e.peak_r, o_peak_right);
                    errors++;
                end
                if (o_rms_left !== e.rms_l) begin
                    $display("%0t: rms_left exp %0d got %0d", $time, e.rms_l, o_rms_left);
                    errors++;
                end
                if (o_rms_right !== e.rms_r) begin
                    $display("%0t: rms_right exp %0d got %0d", $time, e.rms_r, o_rms_right);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BLOCK_LEN: m_block_len = data[LEN_W-1:0];
            REG_PEAK_DEC:  m_peak_dec = data[COEF_W-1:0];
            REG_RMS_ATK:   m_rms_atk = data[COEF_W-1:0];
            REG_RMS_REL:   m_rms_rel = data[COEF_W-1:0];
            REG_PEAK_FLR:  m_peak_flr = data;
            REG_RMS_FLR:   m_rms_flr = data;
            default: ;
        endcase
    endtask

    // wait until every request is accepted and every result has come
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (frame_q.size() != 0 || i_in_valid || levels_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
        frame_t f;
        f.left = l;
        f.right = r;
        frame_q.push_back(f);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'(signed'($urandom_range(0, 512)) - 256);
            3: return 24'($urandom() >> 12);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return Q_ONE;
            2: return 17'h1ffff;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_floor();
        case ($urandom_range(0, 6))
            0: return 24'd0;
            1: return 24'd8388608;
            2: return 24'hffffff;
            3: return 24'($urandom());
            default: return 24'($urandom_range(0, 20000));
        endcase
    endfunction

    // stimulus
    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_left_sample <= '0;
        i_right_sample <= '0;
        i_out_stall <= 1'b0;
        m_block_len = 13'd1024;
        m_peak_dec = Q_ONE;
        m_rms_atk = 0;
        m_rms_rel = 0;
        m_peak_flr = 24'd8389;
        m_rms_flr = 24'd1;
        for (int ch = 0; ch < 2; ch++) begin
            m_blk_peak[ch] = 0;
            m_sq_sum[ch] = 0;
            m_peak_lvl[ch] = 0;
            m_rms_lvl[ch] = 0;
        end
        m_frames = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults apart from a short block
        write_reg(REG_BLOCK_LEN, 24'd2);
        push_frame(24'h800000, 24'h7fffff);
        push_frame(24'h000000, 24'hffffff);
        push_frame(24'h7fffff, 24'h800000);
        push_frame(24'h000001, 24'h000000);
        push_frame(24'h000000, 24'h000000);
        push_frame(24'h000000, 24'h000000);
        drain();

        // zero length acts as one, zero peak decay coefficient, release at full hold, no floors
        write_reg(REG_BLOCK_LEN, 24'd0);
        write_reg(REG_PEAK_DEC, 24'd0);
        write_reg(REG_RMS_ATK, 24'd0);
        write_reg(REG_RMS_REL, 24'd65536);
        write_reg(REG_PEAK_FLR, 24'd0);
        write_reg(REG_RMS_FLR, 24'd0);
        write_reg(REG_UNUSED_A, 24'hffffff);
        write_reg(REG_UNUSED_B, 24'h123456);
        push_frame(24'h800000, 24'h800000);
        push_frame(24'h000010, 24'hfffff0);
        push_frame(24'h000000, 24'h000000);
        push_frame(24'h400000, 24'hc00000);
        drain();

        // oversized length clamps, then shortened mid-block; clamped coeffs,
        // floors at and above full scale
        write_reg(REG_BLOCK_LEN, 24'h1fff);
        write_reg(REG_PEAK_DEC, 24'h1ffff);
        write_reg(REG_RMS_ATK, 24'h1ffff);
        write_reg(REG_PEAK_FLR, 24'd8388608);
        write_reg(REG_RMS_FLR, 24'hffffff);
        for (int i = 0; i < 6; i++) push_frame(rand_sample(), rand_sample());
        drain();
        write_reg(REG_BLOCK_LEN, 24'd3);
        write_reg(REG_PEAK_FLR, 24'd100);
        write_reg(REG_RMS_FLR, 24'd100);
        for (int i = 0; i < 4; i++) push_frame(rand_sample(), rand_sample());
        drain();

        // two longer blocks
        write_reg(REG_BLOCK_LEN, 24'd64);
        for (int i = 0; i < 128; i++) push_frame(rand_sample(), rand_sample());
        drain();

        // back-pressure: one frame per block while the receiver holds off
        write_reg(REG_BLOCK_LEN, 24'd1);
        long_hold_req = 1;
        for (int i = 0; i < 30; i++) push_frame(rand_sample(), rand_sample());
        drain();

        // random phases with random settings
        for (int p = 0; p < 10; p++) begin
            int n;
            write_reg(REG_BLOCK_LEN, ($urandom_range(0, 9) == 0) ?
                      24'($urandom_range(0, 8191)) % 24'd40 : 24'($urandom_range(1, 8)));
            write_reg(REG_PEAK_DEC, rand_coeff());
            write_reg(REG_RMS_ATK, rand_coeff());
            write_reg(REG_RMS_REL, rand_coeff());
            write_reg(REG_PEAK_FLR, rand_floor());
            write_reg(REG_RMS_FLR, rand_floor());
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED_A, 24'($urandom()));
            n = $urandom_range(50, 90);
            for (int i = 0; i < n; i++) push_frame(rand_sample(), rand_sample());
            // sender pauses once mid-phase until all results are in
            if (p == 4) begin
                send_hold = 1;
                do begin
                    @(posedge i_clk);
                    #1;
                end while (i_in_valid || levels_q.size() != 0);
                send_hold = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
